/* hw/rtl/hrbd_pkg.sv */
// types, codes and constants shared by the http response body deframer
package hrbd_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_LOST  = 2'd2,
        MODE_TICK  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LENGTH  = 2'd2,
        PH_CHUNKED = 2'd3
    } phase_t;

    localparam int TIMEOUT_W   = 20;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd20000;
    localparam logic [TIMEOUT_W-1:0] TICK_MAX      = 20'hFFFFF;

    localparam int HEX_W   = 32;
    localparam int CHUNK_W = HEX_W + 1;
    localparam logic [CHUNK_W-1:0] CHUNK_TRAILER = 33'd2;

    localparam int MARK_LEN = 16;
    localparam int MARK_IDX_W = $clog2(MARK_LEN);
    localparam logic [7:0] MARKER [MARK_LEN] = '{
        "C", "o", "n", "t", "e", "n", "t", "-",
        "L", "e", "n", "g", "t", "h", ":", " "
    };

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [2:0] HDR_CRLF_END = 3'd4;

    // control from the top level into the header parser
    typedef struct packed {
        logic start;
        logic byte_en;
    } hdr_ctrl_t;

    // status from the header parser
    typedef struct packed {
        logic done;
        logic length_nonzero;
    } hdr_stat_t;

    function automatic logic is_crlf(input logic [7:0] c);
        return (c == CHAR_CR) || (c == CHAR_LF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // letters outside a-f and A-F count as zero
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if ((c >= "0") && (c <= "9")) d = 4'(c - 8'h30);
        else if ((c >= "a") && (c <= "f")) d = 4'(c - 8'h57);
        else if ((c >= "A") && (c <= "F")) d = 4'(c - 8'h37);
        return d;
    endfunction

endpackage

/* hw/rtl/hrbd_header.sv */
// header parser: content-length marker search, decimal length and end of header
module hrbd_header #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hrbd_pkg::hdr_ctrl_t       ctrl,
    input  logic [7:0]                rx_byte,
    output hrbd_pkg::hdr_stat_t       stat,
    output logic [LENGTH_WIDTH-1:0]   content_length
);
    import hrbd_pkg::*;

    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = '1;

    logic [2:0]              crlf_run_reg, crlf_run_next;
    logic [MARK_IDX_W-1:0]   match_pos_reg, match_pos_next;
    logic                    digits_active_reg, digits_active_next;
    logic                    length_found_reg, length_found_next;
    logic [LENGTH_WIDTH-1:0] length_reg, length_next;

    logic [LENGTH_WIDTH+3:0] len_times10;
    logic [MARK_IDX_W:0]     pos_inc;

    always_comb
    begin
        crlf_run_next      = crlf_run_reg;
        match_pos_next     = match_pos_reg;
        digits_active_next = digits_active_reg;
        length_found_next  = length_found_reg;
        length_next        = length_reg;
        len_times10 = ({4'd0, length_reg} << 3) + ({4'd0, length_reg} << 1)
                      + (LENGTH_WIDTH+4)'(rx_byte - 8'h30);
        pos_inc = {1'b0, match_pos_reg} + 1'b1;

        if (digits_active_reg)
        begin
            if (is_digit(rx_byte))
            begin
                // saturate when the value overflows the length width
                if (len_times10[LENGTH_WIDTH+3:LENGTH_WIDTH] != 4'd0)
                    length_next = LEN_MAX;
                else
                    length_next = len_times10[LENGTH_WIDTH-1:0];
            end
            else
                digits_active_next = 1'b0;
        end
        else if (!length_found_reg)
        begin
            if (rx_byte == MARKER[match_pos_reg])
            begin
                if (pos_inc == (MARK_IDX_W+1)'(MARK_LEN))
                begin
                    length_found_next  = 1'b1;
                    digits_active_next = 1'b1;
                    length_next        = '0;
                    match_pos_next     = '0;
                end
                else
                    match_pos_next = pos_inc[MARK_IDX_W-1:0];
            end
            else if (rx_byte == MARKER[0])
                match_pos_next = MARK_IDX_W'(1);
            else
                match_pos_next = '0;
        end

        if (is_crlf(rx_byte))
        begin
            if (crlf_run_reg < HDR_CRLF_END)
                crlf_run_next = crlf_run_reg + 3'd1;
        end
        else
            crlf_run_next = '0;

        stat.done = (crlf_run_next >= HDR_CRLF_END);
        if (stat.done)
            digits_active_next = 1'b0;
        // a done byte is CR or LF, so it never changes the length
        stat.length_nonzero = (length_reg != '0);
    end

    assign content_length = length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crlf_run_reg      <= '0;
            match_pos_reg     <= '0;
            digits_active_reg <= 1'b0;
            length_found_reg  <= 1'b0;
            length_reg        <= '0;
        end
        else if (ctrl.start)
        begin
            crlf_run_reg      <= '0;
            match_pos_reg     <= '0;
            digits_active_reg <= 1'b0;
            length_found_reg  <= 1'b0;
            length_reg        <= '0;
        end
        else if (ctrl.byte_en)
        begin
            crlf_run_reg      <= crlf_run_next;
            match_pos_reg     <= match_pos_next;
            digits_active_reg <= digits_active_next;
            length_found_reg  <= length_found_next;
            length_reg        <= length_next;
        end
    end

endmodule

/* hw/rtl/http_response_body_deframer_top.sv */
// top level of the http response body deframer
//
// Input stream s_axis: tuser carries the item kind (start, received byte,
// connection lost, millisecond tick) and tdata the received byte. Every
// accepted item yields exactly one item on m_axis: tdata is the body byte,
// tuser[0] marks a valid body byte, tuser[1] success, tlast that this item
// ends the response.
// The result of an accepted item is registered and on m_axis in the cycle after
// it is accepted. One item per cycle is sustained while m_axis_tready is high;
// the parser, length counter, chunk counter and idle timer all update on accept.
// The single result register is the only buffer: while it holds an item the
// receiver has not taken, s_axis_tready stays high only if m_axis_tready is
// high, so a stalled receiver holds back the sender with no item lost.
// cfg_wr_en/cfg_wr_data write the idle timeout in milliseconds; write it
// only while no item is in flight.
// Reset clears all parse state, sets the phase to idle (bytes, disconnects
// and ticks give an all-zero result until a start item) and loads the
// timeout with 20000.
module http_response_body_deframer_top #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    input  logic [1:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // body_byte
    output logic [1:0]  m_axis_tuser,   // body_valid, success
    output logic        m_axis_tlast,   // finished
    input  logic        cfg_wr_en,
    input  logic [hrbd_pkg::TIMEOUT_W-1:0] cfg_wr_data
);
    import hrbd_pkg::*;

    phase_t                  phase_reg, phase_next;
    logic [TIMEOUT_W-1:0]    timeout_reg;
    logic [TIMEOUT_W-1:0]    idle_ticks_reg, idle_ticks_next;
    logic [LENGTH_WIDTH-1:0] body_count_reg, body_count_next;
    logic [CHUNK_W-1:0]      chunk_rem_reg, chunk_rem_next;
    logic [1:0]              size_crlf_reg, size_crlf_next;
    logic [HEX_W-1:0]        hex_value_reg, hex_value_next;

    logic                    out_valid_reg;
    logic                    body_valid_reg, body_valid_next;
    logic [7:0]              body_byte_reg, body_byte_next;
    logic                    fin_reg, fin_next;
    logic                    ok_reg, ok_next;

    logic                    in_fire;
    mode_t                   mode;
    hdr_ctrl_t               hdr_ctrl;
    hdr_stat_t               hdr_stat;
    logic [LENGTH_WIDTH-1:0] content_length;
    logic [TIMEOUT_W-1:0]    tick_inc;
    logic [1:0]              size_crlf_inc;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign mode          = mode_t'(s_axis_tuser);

    assign hdr_ctrl.start   = in_fire && (mode == MODE_START);
    assign hdr_ctrl.byte_en = in_fire && (mode == MODE_BYTE) && (phase_reg == PH_HEADER);

    hrbd_header #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_header (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (hdr_ctrl),
        .rx_byte        (s_axis_tdata),
        .stat           (hdr_stat),
        .content_length (content_length)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        idle_ticks_next = idle_ticks_reg;
        body_count_next = body_count_reg;
        chunk_rem_next  = chunk_rem_reg;
        size_crlf_next  = size_crlf_reg;
        hex_value_next  = hex_value_reg;
        body_valid_next = 1'b0;
        body_byte_next  = 8'd0;
        fin_next        = 1'b0;
        ok_next         = 1'b0;
        tick_inc        = (idle_ticks_reg != TICK_MAX) ? idle_ticks_reg + 1'b1
                                                       : idle_ticks_reg;
        size_crlf_inc   = size_crlf_reg + 2'd1;

        if (mode == MODE_START)
        begin
            phase_next      = PH_HEADER;
            idle_ticks_next = '0;
            body_count_next = '0;
            chunk_rem_next  = '0;
            size_crlf_next  = '0;
            hex_value_next  = '0;
        end
        else if (phase_reg != PH_IDLE)
        begin
            case (mode)
                MODE_LOST:
                begin
                    fin_next   = 1'b1;
                    phase_next = PH_IDLE;
                end
                MODE_TICK:
                begin
                    idle_ticks_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        fin_next   = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                MODE_BYTE:
                begin
                    idle_ticks_next = '0;
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (hdr_stat.done)
                            begin
                                body_count_next = '0;
                                chunk_rem_next  = '0;
                                size_crlf_next  = '0;
                                hex_value_next  = '0;
                                phase_next = hdr_stat.length_nonzero ? PH_LENGTH
                                                                     : PH_CHUNKED;
                            end
                        end
                        PH_LENGTH:
                        begin
                            body_valid_next = 1'b1;
                            body_byte_next  = s_axis_tdata;
                            body_count_next = body_count_reg + 1'b1;
                            if (body_count_next >= content_length)
                            begin
                                fin_next   = 1'b1;
                                ok_next    = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_CHUNKED:
                        begin
                            if (chunk_rem_reg == '0)
                            begin
                                // size line: hex digits ended by two CR/LF bytes
                                if (is_crlf(s_axis_tdata))
                                begin
                                    if (size_crlf_inc >= 2'd2)
                                    begin
                                        size_crlf_next = '0;
                                        hex_value_next = '0;
                                        if (hex_value_reg == '0)
                                        begin
                                            fin_next   = 1'b1;
                                            ok_next    = 1'b1;
                                            phase_next = PH_IDLE;
                                        end
                                        else
                                            chunk_rem_next = {1'b0, hex_value_reg}
                                                             + CHUNK_TRAILER;
                                    end
                                    else
                                        size_crlf_next = size_crlf_inc;
                                end
                                else
                                begin
                                    size_crlf_next = '0;
                                    hex_value_next = {hex_value_reg[HEX_W-5:0],
                                                      hex_digit(s_axis_tdata)};
                                end
                            end
                            else
                            begin
                                // the last two bytes of a chunk are dropped
                                if (chunk_rem_reg > CHUNK_TRAILER)
                                begin
                                    body_valid_next = 1'b1;
                                    body_byte_next  = s_axis_tdata;
                                end
                                chunk_rem_next = chunk_rem_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            idle_ticks_reg <= '0;
            body_count_reg <= '0;
            chunk_rem_reg  <= '0;
            size_crlf_reg  <= '0;
            hex_value_reg  <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            idle_ticks_reg <= idle_ticks_next;
            body_count_reg <= body_count_next;
            chunk_rem_reg  <= chunk_rem_next;
            size_crlf_reg  <= size_crlf_next;
            hex_value_reg  <= hex_value_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= TIMEOUT_RESET;
        else if (cfg_wr_en)
            timeout_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            body_valid_reg <= body_valid_next;
            body_byte_reg  <= body_byte_next;
            fin_reg        <= fin_next;
            ok_reg         <= ok_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = body_byte_reg;
    assign m_axis_tuser  = {ok_reg, body_valid_reg};
    assign m_axis_tlast  = fin_reg;

    // a start item gives an empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (mode == MODE_START)) |=>
            (m_axis_tvalid && !m_axis_tlast && (m_axis_tuser == 2'b00)))
        else $error("start item produced a non-empty result");

    // a finishing item leaves the block idle with the result on the output
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && fin_next) |=>
            ((phase_reg == PH_IDLE) && m_axis_tvalid && m_axis_tlast))
        else $error("finish did not return to idle");

    // success only comes with the end of a response
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("success without finish");

    // body bytes only come from an active body phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && body_valid_next) |->
            ((phase_reg == PH_LENGTH) || (phase_reg == PH_CHUNKED)))
        else $error("body byte outside the body phases");

endmodule
